[rtl/core/dlr_pkg.sv]
// Shared types and defaults for the DDA line rasterizer.
package dlr_pkg;

	localparam int COORD_BITS_DEF = 10;
	localparam int FRAC_BITS_DEF  = 16;

	typedef enum logic {
		OP_START = 1'b0,
		OP_STEP  = 1'b1
	} opcode_t;

	typedef struct packed {
		logic load;      // latch endpoints, set up both dividers
		logic div_step;  // one shift-subtract iteration on both axes
		logic emit;      // write the current pixel to the output register, advance
	} dlr_cmd_t;

	typedef struct packed {
		logic out_free;  // output register empty or being drained this cycle
		logic last;      // the next pixel emitted ends the line
	} dlr_status_t;

endpackage

[rtl/core/dlr_ctrl.sv]
// Controller: sequences line setup, division and pixel stepping.
module dlr_ctrl #(
	parameter int FRAC_BITS = dlr_pkg::FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  dlr_pkg::opcode_t    opcode,
	input  dlr_pkg::dlr_status_t status,
	output dlr_pkg::dlr_cmd_t   cmd
);
	import dlr_pkg::*;

	localparam int CW = (FRAC_BITS > 1) ? $clog2(FRAC_BITS) : 1;
	localparam logic [CW-1:0] CNT_LAST = CW'(FRAC_BITS - 1);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_DRAW = 3'b100
	} state_t;

	state_t        state_q, state_d;
	logic [CW-1:0] cnt_q;
	logic          accept;

	always_comb begin
		s_tready = (state_q == ST_IDLE) || ((state_q == ST_DRAW) && status.out_free);
	end

	assign accept = s_tvalid && s_tready;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && opcode == OP_START) begin
					cmd.load = 1'b1;
					state_d  = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == CNT_LAST) begin
					state_d = ST_DRAW;
				end
			end
			ST_DRAW: begin
				if (accept && opcode == OP_START) begin
					cmd.load = 1'b1;
					state_d  = ST_DIV;
				end else if (accept) begin
					cmd.emit = 1'b1;
					if (status.last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + CW'(1);
			end
		end
	end

endmodule

[rtl/core/dlr_datapath.sv]
// Datapath: span setup, shift-subtract step dividers, position accumulators, output register.
module dlr_datapath #(
	parameter int COORD_BITS = dlr_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = dlr_pkg::FRAC_BITS_DEF,
	parameter int IN_W       = 40,
	parameter int OUT_W      = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dlr_pkg::dlr_cmd_t    cmd,
	output dlr_pkg::dlr_status_t status,
	input  logic [IN_W-1:0]      s_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [OUT_W-1:0]     m_tdata,
	output logic                 m_tlast
);
	import dlr_pkg::*;

	localparam int C  = COORD_BITS;
	localparam int F  = FRAC_BITS;
	localparam int PW = C + F + 2;   // position: sign, guard, integer, fraction
	localparam int QW = F + 1;       // step magnitude, up to 1.0
	localparam int IW = F + 2;       // signed step
	localparam int RW = C + 1;       // divider remainder after shift
	localparam logic [PW-1:0] HALF = PW'(1) << (F - 1);

	logic [C-1:0]  xs, ys, xe, ye, ax, ay, len;
	logic          x_neg, y_neg, len_zero;

	logic [C-1:0]  len_q;
	logic          len_zero_q, x_neg_q, y_neg_q;
	logic [RW-1:0] rem_x_q, rem_y_q;
	logic [QW-1:0] q_x_q, q_y_q;
	logic [PW-1:0] pos_x_q, pos_y_q;
	logic [C:0]    left_q;

	logic [RW-1:0] rx2, ry2;
	logic          bx, by;
	logic [IW-1:0] inc_x, inc_y;

	logic          out_valid_q, out_last_q;
	logic [C-1:0]  out_x_q, out_y_q;

	function automatic logic [C-1:0] trunc_pixel(input logic [PW-1:0] p);
		logic [PW-1:0] mag;
		logic [C-1:0]  whole;
		mag   = -p;
		whole = mag[F+C-1:F];
		if (p[PW-1]) begin
			trunc_pixel = -whole;
		end else begin
			trunc_pixel = p[F+C-1:F];
		end
	endfunction

	// Endpoint setup.
	always_comb begin
		xs       = s_tdata[C-1:0];
		ys       = s_tdata[2*C-1:C];
		xe       = s_tdata[3*C-1:2*C];
		ye       = s_tdata[4*C-1:3*C];
		x_neg    = xe < xs;
		y_neg    = ye < ys;
		ax       = x_neg ? (xs - xe) : (xe - xs);
		ay       = y_neg ? (ys - ye) : (ye - ys);
		len      = (ax >= ay) ? ax : ay;
		len_zero = (len == '0);
	end

	// One restoring division iteration per axis; a zero length forces a zero step.
	always_comb begin
		rx2   = {rem_x_q[C-1:0], 1'b0};
		ry2   = {rem_y_q[C-1:0], 1'b0};
		bx    = !len_zero_q && (rx2 >= {1'b0, len_q});
		by    = !len_zero_q && (ry2 >= {1'b0, len_q});
		inc_x = x_neg_q ? -{1'b0, q_x_q} : {1'b0, q_x_q};
		inc_y = y_neg_q ? -{1'b0, q_y_q} : {1'b0, q_y_q};
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			len_q      <= len;
			len_zero_q <= len_zero;
			x_neg_q    <= x_neg;
			y_neg_q    <= y_neg;
			// Integer quotient bit: set only when the span equals the length.
			q_x_q      <= QW'(!len_zero && (ax == len));
			q_y_q      <= QW'(!len_zero && (ay == len));
			rem_x_q    <= (!len_zero && (ax == len)) ? '0 : {1'b0, ax};
			rem_y_q    <= (!len_zero && (ay == len)) ? '0 : {1'b0, ay};
			pos_x_q    <= x_neg ? ({2'b00, xs, F'(0)} - HALF) : ({2'b00, xs, F'(0)} + HALF);
			pos_y_q    <= y_neg ? ({2'b00, ys, F'(0)} - HALF) : ({2'b00, ys, F'(0)} + HALF);
			left_q     <= {1'b0, len} + (C+1)'(1);
		end else if (cmd.div_step) begin
			q_x_q   <= {q_x_q[QW-2:0], bx};
			q_y_q   <= {q_y_q[QW-2:0], by};
			rem_x_q <= bx ? (rx2 - {1'b0, len_q}) : rx2;
			rem_y_q <= by ? (ry2 - {1'b0, len_q}) : ry2;
		end else if (cmd.emit) begin
			pos_x_q <= pos_x_q + {{(PW-IW){inc_x[IW-1]}}, inc_x};
			pos_y_q <= pos_y_q + {{(PW-IW){inc_y[IW-1]}}, inc_y};
			left_q  <= left_q - (C+1)'(1);
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_x_q    <= trunc_pixel(pos_x_q);
			out_y_q    <= trunc_pixel(pos_y_q);
			out_last_q <= (left_q == (C+1)'(1));
		end
	end

	assign status.out_free = !out_valid_q || m_tready;
	assign status.last     = (left_q == (C+1)'(1));

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_W'({out_y_q, out_x_q});
	assign m_tlast  = out_last_q;

endmodule

[rtl/core/dda_line_rasterizer.sv]
// Top level of the DDA line rasterizer: stream ports, controller and datapath.
//
// A start request (s_tuser = 0) carries both endpoints and emits nothing; the
// block then runs a shift-subtract divider that forms both signed Q.FRAC_BITS
// steps at once, one quotient bit per cycle, with s_tready low until the
// division ends. After that each step request (s_tuser = 1) emits one pixel,
// truncated toward zero on each axis, and steps can follow one per cycle while
// m_tready stays high: the output register frees itself in the cycle that
// m_tready drains it. A line of length L (longer axis span) yields L+1 pixels
// and the last one carries m_tlast; a zero-length line yields a single pixel at
// the first endpoint. A step request while no line is active is taken and
// dropped. A start request while drawing abandons the current line.
module dda_line_rasterizer #(
	parameter int COORD_BITS = dlr_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = dlr_pkg::FRAC_BITS_DEF,
	localparam int IN_W      = ((4 * COORD_BITS + 7) / 8) * 8,
	localparam int OUT_W     = ((2 * COORD_BITS + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // x_start, y_start, x_end, y_end, zero pad
	input  dlr_pkg::opcode_t s_tuser,   // opcode
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,   // pixel_x, pixel_y, zero pad
	output logic             m_tlast    // last_pixel
);
	import dlr_pkg::*;

	dlr_cmd_t    cmd;
	dlr_status_t status;

	// Controller: accepts requests, counts divider iterations, ends the line.
	dlr_ctrl #(
		.FRAC_BITS(FRAC_BITS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.opcode  (s_tuser),
		.status  (status),
		.cmd     (cmd)
	);

	// Datapath: holds position, steps and pixel count; drives the result port.
	dlr_datapath #(
		.COORD_BITS(COORD_BITS),
		.FRAC_BITS (FRAC_BITS),
		.IN_W      (IN_W),
		.OUT_W     (OUT_W)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.status  (status),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

endmodule
